// ----- src/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with positional insert.
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_INSERT_AT  = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Decoded command broadcast from the controller to every cell.
    typedef struct packed {
        logic             ins;
        logic             pop_front;
        logic             pop_rear;
        logic [CNT_W-1:0] ins_pos;
        status_t          status;
        logic [CNT_W-1:0] count;
    } ctl_t;

endpackage

// ----- src/bdq_cell.sv -----
// One storage cell of the deque chain: hold, take the new value, or take a neighbor.
module bdq_cell (
    input  logic                           aclk,
    input  logic                           advance,
    input  bdq_pkg::ctl_t                  ctl,
    input  logic [bdq_pkg::IDX_W-1:0]      idx,
    input  logic [bdq_pkg::DATA_W-1:0]     value,
    input  logic [bdq_pkg::DATA_W-1:0]     left_data,
    input  logic [bdq_pkg::DATA_W-1:0]     right_data,
    output logic [bdq_pkg::DATA_W-1:0]     data
);

    logic [bdq_pkg::DATA_W-1:0] data_reg;
    logic [bdq_pkg::DATA_W-1:0] data_next;
    logic [bdq_pkg::CNT_W-1:0]  idx_x;

    assign idx_x = bdq_pkg::CNT_W'(idx);

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (idx_x == ctl.ins_pos) begin
                data_next = value;
            end else if (idx_x > ctl.ins_pos) begin
                data_next = left_data;
            end
        end else if (ctl.pop_front) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ----- src/bdq_ctrl.sv -----
// Opcode decode, status checks and the element count register.
module bdq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [bdq_pkg::OP_W-1:0]      opcode,
    input  logic [bdq_pkg::POS_W-1:0]     position,
    output bdq_pkg::ctl_t                 ctl
);

    logic [bdq_pkg::CNT_W-1:0] count_reg;
    logic [bdq_pkg::CNT_W-1:0] count_next;
    logic [bdq_pkg::CMP_W-1:0] pos_x;
    logic [bdq_pkg::CMP_W-1:0] cnt_x;
    logic                      full;
    logic                      empty;

    assign pos_x = bdq_pkg::CMP_W'(position);
    assign cnt_x = bdq_pkg::CMP_W'(count_reg);
    assign full  = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        ctl           = '0;
        ctl.status    = bdq_pkg::ST_OK;
        count_next    = count_reg;
        case (bdq_pkg::op_t'(opcode))
            bdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    ctl.status = bdq_pkg::ST_FULL;
                end else begin
                    ctl.ins     = 1'b1;
                    ctl.ins_pos = '0;
                    count_next  = count_reg + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    ctl.status = bdq_pkg::ST_FULL;
                end else begin
                    ctl.ins     = 1'b1;
                    ctl.ins_pos = count_reg;
                    count_next  = count_reg + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_INSERT_AT: begin
                if (full) begin
                    ctl.status = bdq_pkg::ST_FULL;
                end else if (pos_x > cnt_x) begin
                    ctl.status = bdq_pkg::ST_BADPOS;
                end else begin
                    ctl.ins     = 1'b1;
                    ctl.ins_pos = bdq_pkg::CNT_W'(pos_x);
                    count_next  = count_reg + bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    ctl.status = bdq_pkg::ST_EMPTY;
                end else begin
                    ctl.pop_front = 1'b1;
                    count_next    = count_reg - bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    ctl.status = bdq_pkg::ST_EMPTY;
                end else begin
                    ctl.pop_rear = 1'b1;
                    count_next   = count_reg - bdq_pkg::CNT_W'(1);
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        ctl.count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (advance) begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/bounded_deque_with_positional_insert.sv -----
// Top level of the bounded deque with positional insert: cell chain and result register.
//
// Holds an ordered sequence of up to DEPTH (16) signed 32-bit elements, index 0
// at the front, in a row of cells. Every accepted transaction on the s_ side
// carries an opcode (push front, push rear, pop front, pop rear, insert at
// position) and yields exactly one result transaction on the m_ side with the
// removed value (zero unless a pop succeeds), a status (ok, empty on pop, full
// on insert, position beyond count) and the element count after the operation.
// Every operation, a positional insert included, completes on acceptance: all
// cells shift toward or away from the insertion point together, so the block
// takes one transaction per cycle while the m_ side keeps up. The result sits
// in an output register from the cycle after acceptance; s_tready drops only
// while that register holds a result that the m_ side has not yet taken. Full
// takes priority over a bad position; unused opcodes change nothing and report
// ok. Reset clears only the count and m_tvalid, so no clearing pass is needed.
module bounded_deque_with_positional_insert (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] opcode, [34:3] value, [39:35] position
    input  logic [bdq_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] removed_value, [33:32] status, [38:34] element_count, [39] zero
    output logic [bdq_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic                          accept;
    logic [bdq_pkg::OP_W-1:0]      in_opcode;
    logic [bdq_pkg::DATA_W-1:0]    in_value;
    logic [bdq_pkg::POS_W-1:0]     in_position;
    bdq_pkg::ctl_t                 ctl;

    logic [bdq_pkg::DATA_W-1:0]    cell_data  [bdq_pkg::DEPTH];
    logic [bdq_pkg::DATA_W-1:0]    left_data  [bdq_pkg::DEPTH];
    logic [bdq_pkg::DATA_W-1:0]    right_data [bdq_pkg::DEPTH];

    logic [bdq_pkg::DATA_W-1:0]    removed;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [bdq_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bdq_pkg::M_TDATA_W-1:0] m_tdata_next;

    // Unpack the input transaction.
    assign in_opcode   = s_tdata[2:0];
    assign in_value    = s_tdata[34:3];
    assign in_position = s_tdata[39:35];

    // Accept whenever the result register is free or being drained this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (accept),
        .opcode   (in_opcode),
        .position (in_position),
        .ctl      (ctl)
    );

    // Chain of cells: each one sees its neighbors; the ends see zero.
    genvar i;
    generate
        for (i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_first
                assign left_data[i] = '0;
            end else begin : g_left
                assign left_data[i] = cell_data[i-1];
            end
            if (i == bdq_pkg::DEPTH - 1) begin : g_last
                assign right_data[i] = '0;
            end else begin : g_right
                assign right_data[i] = cell_data[i+1];
            end

            bdq_cell u_cell (
                .aclk       (aclk),
                .advance    (accept),
                .ctl        (ctl),
                .idx        (bdq_pkg::IDX_W'(i)),
                .value      (in_value),
                .left_data  (left_data[i]),
                .right_data (right_data[i]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    // Pick the departing element: front cell, or the last occupied cell, whose
    // index equals the count after the pop.
    always_comb begin
        removed = '0;
        if (ctl.pop_front) begin
            removed = cell_data[0];
        end else if (ctl.pop_rear) begin
            removed = cell_data[ctl.count[bdq_pkg::IDX_W-1:0]];
        end
    end

    // Result register: load on accept, drop once the m_ side takes it.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, bdq_pkg::ECNT_W'(ctl.count), ctl.status, removed};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // A failed operation reports zero as the removed value.
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != bdq_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero removed value on a failed operation");

    // Empty status only with an empty deque; full status only with a full one.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == bdq_pkg::ST_EMPTY) |-> (m_tdata[38:34] == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == bdq_pkg::ST_FULL)
        |-> (m_tdata[38:34] == bdq_pkg::ECNT_W'(bdq_pkg::DEPTH)))
        else $error("full status with count below depth");

    // The count never goes past the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("element count beyond depth");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the bounded deque with positional insert.
`timescale 1ns / 1ps

module testbench;

    import bdq_pkg::*;

    localparam int CLK_HALF    = 6;     // 12 ns period
    localparam int RESET_LEN   = 6;
    localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int HOLD_LEN    = 60;    // receiver hold-off for the back-pressure phase
    localparam int PHASE_ITEMS = 115;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic              pad;
        logic [ECNT_W-1:0] count;
        status_t           status;
        logic [DATA_W-1:0] removed;
    } deque_result_t;

    // Scoreboard: keeps a shadow copy of the deque contents and the results it predicts.
    class deque_scoreboard;
        logic [DATA_W-1:0] shadow[$];
        deque_result_t     pending[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        // Apply one accepted command to the shadow deque and queue its result.
        function void note_input(logic [OP_W-1:0] opcode, logic [DATA_W-1:0] value,
                                 logic [POS_W-1:0] position);
            deque_result_t r;
            r = '{pad: 1'b0, count: '0, status: ST_OK, removed: '0};
            case (opcode)
                OP_PUSH_FRONT, OP_PUSH_REAR, OP_INSERT_AT: begin
                    // full wins over a bad position
                    if (shadow.size() >= DEPTH)
                        r.status = ST_FULL;
                    else if (opcode == OP_PUSH_FRONT)
                        shadow.push_front(value);
                    else if (opcode == OP_PUSH_REAR)
                        shadow.push_back(value);
                    else if (int'(position) > shadow.size())
                        r.status = ST_BADPOS;
                    else
                        shadow.insert(int'(position), value);
                end
                OP_POP_FRONT: begin
                    if (shadow.size() == 0) r.status = ST_EMPTY;
                    else r.removed = shadow.pop_front();
                end
                OP_POP_REAR: begin
                    if (shadow.size() == 0) r.status = ST_EMPTY;
                    else r.removed = shadow.pop_back();
                end
                default: ;  // unused opcodes leave everything alone
            endcase
            r.count = ECNT_W'(shadow.size());
            pending.push_back(r);
        endfunction

        // Compare one result transaction against the oldest prediction.
        function void check_result(logic [M_TDATA_W-1:0] tdata);
            deque_result_t got;
            deque_result_t exp_r;
            got = deque_result_t'(tdata);
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: tdata %h", $time, tdata);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.removed !== exp_r.removed) begin
                $display("%0t: removed_value expected %h, actual %h",
                         $time, exp_r.removed, got.removed);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, exp_r.status, got.status);
                errors++;
            end
            if (got.count !== exp_r.count) begin
                $display("%0t: element_count expected %0d, actual %0d",
                         $time, exp_r.count, got.count);
                errors++;
            end
            if (got.pad !== exp_r.pad) begin
                $display("%0t: tdata pad bit expected %b, actual %b",
                         $time, exp_r.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] opcode, [34:3] value, [39:35] position
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] removed_value, [33:32] status, [38:34] element_count, [39] zero
    logic [M_TDATA_W-1:0] m_tdata;

    deque_scoreboard sb;

    int src_idle_pct  = 0;  // chance in 100 that the sender idles a cycle
    int snk_stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
    int hold_asked    = 0;  // written by the stimulus only
    int hold_done     = 0;  // written by the receiver only
    int quiet_cycles  = 0;

    bounded_deque_with_positional_insert uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off on request so the output
    // register stays full and the block has to drop s_tready.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check every result transaction; values are sampled before this edge's updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command and hold it until the block takes it. s_tvalid is left
    // high on return, so the next call either idles it or reloads it once.
    task automatic send_cmd(logic [OP_W-1:0] opcode, logic [DATA_W-1:0] value,
                            logic [POS_W-1:0] position);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {position, value, opcode};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(opcode, value, position);
    endtask

    // Mostly extreme or random element values.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r == 2) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Random commands. The insert/remove mix swings every few dozen commands so
    // the deque repeatedly runs all the way to full and back down to empty.
    task automatic random_cmds(int n);
        int               done_cnt;
        int               grow_pct;
        int               r;
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        done_cnt = 0;
        grow_pct = 25;
        while (done_cnt < n) begin
            if (done_cnt % 40 == 39) grow_pct = (grow_pct > 50) ? 25 : 80;
            r = $urandom_range(99);
            if (r < 3) begin
                opcode = OP_W'($urandom_range(7, 5));  // ignored by the block
            end else if ($urandom_range(99) < grow_pct) begin
                case ($urandom_range(2))
                    0:       opcode = OP_PUSH_FRONT;
                    1:       opcode = OP_PUSH_REAR;
                    default: opcode = OP_INSERT_AT;
                endcase
            end else begin
                opcode = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            end
            // mostly legal positions, some anywhere in the field
            if ($urandom_range(99) < 80)
                position = POS_W'($urandom_range(sb.shadow.size(), 0));
            else
                position = POS_W'($urandom_range(31));
            send_cmd(opcode, pick_value(), position);
            if (opcode <= OP_INSERT_AT) done_cnt++;
        end
    endtask

    // Directed corner cases: empty pops, ignored opcodes, single-element pops,
    // positional inserts at front, rear, middle and beyond the count, then full.
    task automatic directed_cmds();
        send_cmd(OP_POP_FRONT, 32'h0, 5'd0);
        send_cmd(OP_POP_REAR, 32'h0, 5'd0);
        send_cmd(OP_W'(5), 32'hFFFF_FFFF, 5'd31);
        send_cmd(OP_W'(7), 32'h1234_5678, 5'd0);
        send_cmd(OP_PUSH_FRONT, 32'h8000_0000, 5'd0);
        send_cmd(OP_POP_REAR, 32'h0, 5'd0);
        send_cmd(OP_PUSH_REAR, 32'h7FFF_FFFF, 5'd0);
        send_cmd(OP_POP_FRONT, 32'h0, 5'd0);
        send_cmd(OP_INSERT_AT, 32'h0, 5'd0);
        send_cmd(OP_INSERT_AT, 32'hFFFF_FFFF, 5'd1);
        send_cmd(OP_INSERT_AT, 32'h5555_AAAA, 5'd1);
        send_cmd(OP_INSERT_AT, 32'h1, 5'd4);
        send_cmd(OP_INSERT_AT, 32'h2, 5'd31);
        // fill to DEPTH, then hit the full checks (full beats a bad position)
        while (sb.shadow.size() < DEPTH)
            send_cmd($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_value(), 5'd0);
        send_cmd(OP_PUSH_FRONT, 32'hAAAA_5555, 5'd0);
        send_cmd(OP_PUSH_REAR, 32'hAAAA_5555, 5'd0);
        send_cmd(OP_INSERT_AT, 32'hAAAA_5555, 5'd31);
        send_cmd(OP_INSERT_AT, 32'hAAAA_5555, 5'd0);
    endtask

    initial begin
        sb = new();
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_cmds();

        // idle phases: none, sender idles, receiver stalls, both
        src_idle_pct = 0;  snk_stall_pct = 0;  random_cmds(PHASE_ITEMS);
        src_idle_pct = 86; snk_stall_pct = 0;  random_cmds(PHASE_ITEMS);
        src_idle_pct = 0;  snk_stall_pct = 86; random_cmds(PHASE_ITEMS);
        src_idle_pct = 23; snk_stall_pct = 23; random_cmds(PHASE_ITEMS);

        // back-pressure: receiver holds off while the sender keeps offering
        src_idle_pct = 0;  snk_stall_pct = 0;
        hold_asked = hold_asked + 1;
        random_cmds(20);

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bdq_pkg.sv
src/bdq_cell.sv
src/bdq_ctrl.sv
src/bounded_deque_with_positional_insert.sv
verif/testbench.sv
